/* rtl/core/mtc_pkg.sv */
// Shared types and codes for the match timer/counter.
package mtc_pkg;

   // transaction function codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   // word register indexes
   localparam logic [4:0] REG_FLAGS     = 5'd0;
   localparam logic [4:0] REG_RUN       = 5'd1;
   localparam logic [4:0] REG_COUNT     = 5'd2;
   localparam logic [4:0] REG_PRE_LIMIT = 5'd3;
   localparam logic [4:0] REG_PRE_COUNT = 5'd4;
   localparam logic [4:0] REG_ACTIONS   = 5'd5;
   localparam logic [4:0] REG_MATCH0    = 5'd6;
   localparam logic [4:0] REG_MATCH3    = 5'd9;
   localparam logic [4:0] REG_EXT_MATCH = 5'd15;
   localparam logic [4:0] REG_MODE      = 5'd28;

   // run control bits
   localparam int RUN_ENABLE = 0;
   localparam int RUN_HOLD   = 1;

   // match action bits
   localparam int ACT_IRQ     = 0;
   localparam int ACT_RESTART = 1;
   localparam int ACT_STOP    = 2;

   // external match pin actions
   localparam logic [1:0] EXT_NONE   = 2'd0;
   localparam logic [1:0] EXT_LOW    = 2'd1;
   localparam logic [1:0] EXT_HIGH   = 2'd2;
   localparam logic [1:0] EXT_TOGGLE = 2'd3;

   // count modes
   localparam logic [1:0] MODE_TIMER   = 2'd0;
   localparam logic [1:0] MODE_RISING  = 2'd1;
   localparam logic [1:0] MODE_FALLING = 2'd2;
   localparam logic [1:0] MODE_BOTH    = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [4:0]  reg_index;
      logic [31:0] write_data;
      logic [3:0]  capture_pins;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
      logic [3:0]  match_pins;
      logic [31:0] count_now;
   } rsp_payload_type;

endpackage

/* rtl/core/mtc_stream_if.sv */
// Valid/ready stream channel carrying one payload per transaction.
interface mtc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/mtc_timer_core.sv */
// Timer state registers and the single-pass update for one transaction.
module mtc_timer_core #(
   parameter int NUM_MATCH   = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  mtc_pkg::req_payload_type item,
   output mtc_pkg::rsp_payload_type result
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [31:0]            pre_count_ff, pre_count_in;
   logic [31:0]            pre_limit_ff, pre_limit_in;
   logic [1:0]             run_ff, run_in;
   logic [3*NUM_MATCH-1:0] actions_ff, actions_in;
   logic [COUNT_WIDTH-1:0] match_ff [NUM_MATCH];
   logic [COUNT_WIDTH-1:0] match_in [NUM_MATCH];
   logic [NUM_MATCH-1:0]   flags_ff, flags_in;
   logic [NUM_MATCH-1:0]   ext_pins_ff, ext_pins_in;
   logic [2*NUM_MATCH-1:0] ext_ctl_ff, ext_ctl_in;
   logic [3:0]             mode_ff, mode_in;
   logic [3:0]             last_pins_ff, last_pins_in;

   logic [COUNT_WIDTH-1:0] next_count;
   logic [2:0]             act;
   logic [1:0]             ctl;
   logic                   pin_now;
   logic                   pin_was;
   logic                   count_event;
   logic [31:0]            read_data;

   always_comb begin
      count_in     = count_ff;
      pre_count_in = pre_count_ff;
      pre_limit_in = pre_limit_ff;
      run_in       = run_ff;
      actions_in   = actions_ff;
      match_in     = match_ff;
      flags_in     = flags_ff;
      ext_pins_in  = ext_pins_ff;
      ext_ctl_in   = ext_ctl_ff;
      mode_in      = mode_ff;
      last_pins_in = last_pins_ff;
      next_count   = count_ff + 1'b1;
      act          = '0;
      ctl          = mtc_pkg::EXT_NONE;
      pin_now      = item.capture_pins[mode_ff[3:2]];
      pin_was      = last_pins_ff[mode_ff[3:2]];
      count_event  = 1'b0;

      case (mode_ff[1:0])
         mtc_pkg::MODE_TIMER:   count_event = 1'b1;
         mtc_pkg::MODE_RISING:  count_event = pin_now && !pin_was;
         mtc_pkg::MODE_FALLING: count_event = !pin_now && pin_was;
         default:               count_event = pin_now != pin_was;
      endcase

      case (item.func)
         mtc_pkg::FUNC_TICK: begin
            last_pins_in = item.capture_pins;
            if (run_ff[mtc_pkg::RUN_HOLD]) begin
               count_in     = '0;
               pre_count_in = '0;
            end else if (run_ff[mtc_pkg::RUN_ENABLE] && count_event) begin
               if (pre_count_ff == pre_limit_ff) begin
                  pre_count_in = '0;
                  // matches apply in order; a restart feeds zero to later compares
                  for (int i = 0; i < NUM_MATCH; i++) begin
                     if (next_count == match_ff[i]) begin
                        act = actions_ff[3*i +: 3];
                        ctl = ext_ctl_ff[2*i +: 2];
                        if (act[mtc_pkg::ACT_IRQ]) flags_in[i] = 1'b1;
                        case (ctl)
                           mtc_pkg::EXT_LOW:    ext_pins_in[i] = 1'b0;
                           mtc_pkg::EXT_HIGH:   ext_pins_in[i] = 1'b1;
                           mtc_pkg::EXT_TOGGLE: ext_pins_in[i] = !ext_pins_in[i];
                           default:             ;
                        endcase
                        if (act[mtc_pkg::ACT_STOP]) run_in[mtc_pkg::RUN_ENABLE] = 1'b0;
                        if (act[mtc_pkg::ACT_RESTART]) next_count = '0;
                     end
                  end
                  count_in = next_count;
               end else begin
                  pre_count_in = pre_count_ff + 1'b1;
               end
            end
         end
         mtc_pkg::FUNC_WRITE: begin
            unique case (item.reg_index) inside
               mtc_pkg::REG_FLAGS: flags_in = flags_ff & ~item.write_data[NUM_MATCH-1:0];
               mtc_pkg::REG_RUN: begin
                  run_in = item.write_data[1:0];
                  if (item.write_data[mtc_pkg::RUN_HOLD]) begin
                     count_in     = '0;
                     pre_count_in = '0;
                  end
               end
               mtc_pkg::REG_COUNT:     count_in = item.write_data[COUNT_WIDTH-1:0];
               mtc_pkg::REG_PRE_LIMIT: pre_limit_in = item.write_data;
               mtc_pkg::REG_PRE_COUNT: pre_count_in = item.write_data;
               mtc_pkg::REG_ACTIONS:   actions_in = item.write_data[3*NUM_MATCH-1:0];
               [mtc_pkg::REG_MATCH0:mtc_pkg::REG_MATCH3]: begin
                  for (int i = 0; i < NUM_MATCH; i++) begin
                     if (item.reg_index == 5'(mtc_pkg::REG_MATCH0 + i)) begin
                        match_in[i] = item.write_data[COUNT_WIDTH-1:0];
                     end
                  end
               end
               mtc_pkg::REG_EXT_MATCH: begin
                  ext_pins_in = item.write_data[NUM_MATCH-1:0];
                  ext_ctl_in  = item.write_data[4 +: 2*NUM_MATCH];
               end
               mtc_pkg::REG_MODE: mode_in = item.write_data[3:0];
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // register read mux; reads leave the state alone
   always_comb begin
      read_data = '0;
      if (item.func == mtc_pkg::FUNC_READ) begin
         unique case (item.reg_index) inside
            mtc_pkg::REG_FLAGS:     read_data = 32'(flags_ff);
            mtc_pkg::REG_RUN:       read_data = 32'(run_ff);
            mtc_pkg::REG_COUNT:     read_data = 32'(count_ff);
            mtc_pkg::REG_PRE_LIMIT: read_data = pre_limit_ff;
            mtc_pkg::REG_PRE_COUNT: read_data = pre_count_ff;
            mtc_pkg::REG_ACTIONS:   read_data = 32'(actions_ff);
            [mtc_pkg::REG_MATCH0:mtc_pkg::REG_MATCH3]: begin
               for (int i = 0; i < NUM_MATCH; i++) begin
                  if (item.reg_index == 5'(mtc_pkg::REG_MATCH0 + i)) begin
                     read_data = 32'(match_ff[i]);
                  end
               end
            end
            mtc_pkg::REG_EXT_MATCH: read_data = 32'({ext_ctl_ff, 4'(ext_pins_ff)});
            mtc_pkg::REG_MODE:      read_data = 32'(mode_ff);
            default:                read_data = '0;
         endcase
      end
   end

   assign result.read_data  = read_data;
   assign result.irq        = |flags_in;
   assign result.match_pins = 4'(ext_pins_in);
   assign result.count_now  = 32'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pre_count_ff <= '0;
         pre_limit_ff <= '0;
         run_ff       <= '0;
         actions_ff   <= '0;
         flags_ff     <= '0;
         ext_pins_ff  <= '0;
         ext_ctl_ff   <= '0;
         mode_ff      <= '0;
         last_pins_ff <= '0;
         for (int i = 0; i < NUM_MATCH; i++) match_ff[i] <= '0;
      end else if (item_valid) begin
         count_ff     <= count_in;
         pre_count_ff <= pre_count_in;
         pre_limit_ff <= pre_limit_in;
         run_ff       <= run_in;
         actions_ff   <= actions_in;
         flags_ff     <= flags_in;
         ext_pins_ff  <= ext_pins_in;
         ext_ctl_ff   <= ext_ctl_in;
         mode_ff      <= mode_in;
         last_pins_ff <= last_pins_in;
         match_ff     <= match_in;
      end
   end

endmodule

/* rtl/core/match_timer_counter_unit.sv */
// Match timer/counter: input register, timer core and result register.
// A request transaction passes through the input register and then the result register before its response is valid.
// Throughput: one transaction per cycle while the response is not stalled; the core updates all state in one pass.
// A stalled response holds the result register and then the input register.
// Reset (synchronous, active high) zeroes every timer register and empties both stages.
module match_timer_counter_unit #(
   parameter int NUM_MATCH   = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   mtc_stream_if.sink    req_chan,
   mtc_stream_if.source  rsp_chan
);

   logic                     in_valid_ff, in_valid_in;
   mtc_pkg::req_payload_type in_item_ff;
   logic                     out_valid_ff, out_valid_in;
   mtc_pkg::rsp_payload_type out_item_ff;
   mtc_pkg::rsp_payload_type core_result;
   logic                     advance;
   logic                     process;
   logic                     accept;

   assign advance = !out_valid_ff || rsp_chan.ready;
   assign process = in_valid_ff && advance;
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

   assign in_valid_in  = accept ? 1'b1 : (in_valid_ff && !process);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   mtc_timer_core #(
      .NUM_MATCH   (NUM_MATCH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (process),
      .item       (in_item_ff),
      .result     (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_item_ff <= req_chan.payload;
      if (process) out_item_ff <= core_result;
   end

`ifndef SYNTHESIS
   // a processed transaction always lands in the result register
   assert property (@(posedge clock) disable iff (reset) process |=> out_valid_ff)
      else $error("processed transaction did not reach the result register");

   // a stalled input stage keeps its transaction
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("stalled input transaction was lost or changed");

   // a waiting result is neither dropped nor overwritten
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("stalled response was lost or changed");

   // reported count stays inside the counter width
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((64'(out_item_ff.count_now) >> COUNT_WIDTH) == 64'd0))
      else $error("count exceeds counter width");
`endif

endmodule
